### rtl/ceb_pkg.sv
// Shared types and constants of the easing curve blend block.
// Used by ceb_regs, ceb_div and the top level easing_curve_blend.
`default_nettype none

package ceb_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 34;
	localparam int COORD_W = 17;
	localparam int VALUE_W = 16;

	localparam logic [COORD_W-1:0] ONE_Q16 = 17'h10000;

	localparam logic [CFG_INDEX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_POINT_COUNT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_POINT_FIRST = 3'd2;

	typedef struct packed {
		logic       mode;
		logic [2:0] count;
	} ceb_cfg_t;

	typedef struct packed {
		logic               start;
		logic [COORD_W-1:0] num;
		logic [COORD_W-1:0] den;
	} ceb_div_req_t;

endpackage

`default_nettype wire

### rtl/ceb_regs.sv
// Configuration registers: mode, point count and the curve points.
// Depends on ceb_pkg for register indexes and the configuration struct.
`default_nettype none

module ceb_regs #(
	parameter int MAX_POINTS = 6,
	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [ceb_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  wire logic [ceb_pkg::CFG_DATA_W-1:0]     wr_data,
	input  wire logic [IW-1:0]                      rd_idx,
	output ceb_pkg::ceb_cfg_t                       cfg,
	output logic      [ceb_pkg::COORD_W-1:0]        rd_x,
	output logic      [ceb_pkg::COORD_W-1:0]        rd_y
);

	logic                              mode_q;
	logic [2:0]                        count_q;
	logic [ceb_pkg::CFG_DATA_W-1:0]    point_q [MAX_POINTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			count_q <= 3'd0;
		end else if (wr_en) begin
			if (wr_index == ceb_pkg::REG_MODE) begin
				mode_q <= wr_data[0];
			end
			if (wr_index == ceb_pkg::REG_POINT_COUNT) begin
				count_q <= wr_data[2:0];
			end
		end
	end

	for (genvar g = 0; g < MAX_POINTS; g++) begin : g_point
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				point_q[g] <= '0;
			end else if (wr_en && wr_index == 3'(ceb_pkg::REG_POINT_FIRST + g)) begin
				point_q[g] <= wr_data;
			end
		end
	end

	always_comb begin
		cfg.mode = mode_q;
		cfg.count = (count_q > 3'(MAX_POINTS)) ? 3'(MAX_POINTS) : count_q;
		rd_x = point_q[rd_idx][33:17];
		rd_y = point_q[rd_idx][16:0];
	end

endmodule

`default_nettype wire

### rtl/ceb_div.sv
// Restoring divider, one quotient bit per cycle, for the local fraction.
// Depends on ceb_pkg for the request struct; expects num <= den.
`default_nettype none

module ceb_div #(
	parameter int QW = 17
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ceb_pkg::ceb_div_req_t   req,
	output logic                         done,
	output logic [QW-1:0]                quot
);

	localparam int CW = $clog2(QW + 1);
	localparam int RW = ceb_pkg::COORD_W + 1;

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [RW-1:0]     rem_q;
	logic [ceb_pkg::COORD_W-1:0] den_q;
	logic [QW-1:0]     quo_q;
	logic [RW:0]       diff;
	logic              qbit;
	logic [RW-1:0]     rem_keep;

	always_comb begin
		diff = (RW + 1)'(rem_q) - (RW + 1)'(den_q);
		qbit = !diff[RW];
		rem_keep = qbit ? diff[RW-1:0] : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= RW'(req.num);
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= {rem_keep[RW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

### rtl/ceb_mul.sv
// Shared signed by unsigned multiplier with a registered product.
// No package dependency; operands are chosen by the sequencer each cycle.
`default_nettype none

module ceb_mul #(
	parameter int AW = 18,
	parameter int BW = 17
) (
	input  wire logic                     clk,
	input  wire logic signed [AW-1:0]     a,
	input  wire logic        [BW-1:0]     b,
	output logic signed      [AW+BW:0]    prod
);

	logic signed [AW+BW:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * $signed({1'b0, b});
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

### rtl/easing_curve_blend.sv
// Top level of the easing curve blend block: sequencer, cosine table and streams.
// Depends on ceb_pkg, ceb_regs, ceb_div and ceb_mul.
//
// Each transfer on the input stream is evaluated against an easing curve of up
// to MAX_POINTS configured points, searched one point per cycle, and produces
// one output transfer with the blended value and the curve weight. A bit-serial
// divider forms the local fraction between the two bounding points, and smooth
// mode shapes it through the cosine table; an exact match on a point skips both.
// A stall on the output stream holds the sequencer in its output state. The
// input is not ready while an item is in work, but a new item is taken while
// the previous result still waits in the output register. Configuration
// writes are always accepted and must only be made while idle.
`default_nettype none

module easing_curve_blend #(
	parameter int MAX_POINTS = 6,
	parameter int COS_TABLE_BITS = 8,
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [33:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// start_value [15:0], end_value [31:16], progress [48:32], zero [55:49]
	input  wire logic [55:0]  s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// blended_value [15:0], end_weight [32:16], zero [39:33]
	output logic [39:0]       m_axis_tdata
);

	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CWD = ceb_pkg::COORD_W;
	localparam int TW = FRAC_BITS + 1;
	localparam int ROM_N = 1 << COS_TABLE_BITS;
	localparam int RIW = COS_TABLE_BITS + 1;
	localparam int PSW = FRAC_BITS + COS_TABLE_BITS + 1;
	localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
	localparam int BW = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
	localparam int PW = AW + BW + 1;
	localparam int ACW = 35;
	localparam logic [TW-1:0] FULL = TW'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SM_IDX,
		ST_SM_MUL,
		ST_SM_FIN,
		ST_Y_MUL,
		ST_Y_FIN,
		ST_O_MUL,
		ST_O_FIN,
		ST_OUT
	} state_t;

	// Entry i of the table holds (1 - cos(pi * i / 2^(COS_TABLE_BITS+1))) / 2.
	function automatic longint unsigned cos_entry(input int unsigned idx);
		longint unsigned a;
		longint unsigned a2;
		longint unsigned term;
		longint unsigned s;
		longint sum;
		int unsigned sh;
		a = (PI_Q30 * 64'(idx)) >> (COS_TABLE_BITS + 1);
		a2 = (a * a) >> 30;
		term = a2 >> 1;
		sum = signed'(term);
		term = ((term * a2) >> 30) / 64'd12;
		sum = sum - signed'(term);
		term = ((term * a2) >> 30) / 64'd30;
		sum = sum + signed'(term);
		term = ((term * a2) >> 30) / 64'd56;
		sum = sum - signed'(term);
		term = ((term * a2) >> 30) / 64'd90;
		sum = sum + signed'(term);
		term = ((term * a2) >> 30) / 64'd132;
		sum = sum - signed'(term);
		term = ((term * a2) >> 30) / 64'd182;
		sum = sum + signed'(term);
		term = ((term * a2) >> 30) / 64'd240;
		sum = sum - signed'(term);
		if (sum < 0) begin
			sum = 0;
		end
		s = unsigned'(sum) >> 1;
		sh = 30 - FRAC_BITS;
		return (s + (64'd1 << (sh - 1))) >> sh;
	endfunction

	logic [FRAC_BITS-1:0] cos_rom [ROM_N + 2];

	for (genvar g = 0; g < ROM_N + 2; g++) begin : g_rom
		localparam logic [FRAC_BITS-1:0] ENTRY =
			FRAC_BITS'(cos_entry((g > ROM_N) ? ROM_N : g));
		assign cos_rom[g] = ENTRY;
	end

	state_t                  state_q;
	logic signed [15:0]      sv_q;
	logic signed [15:0]      ev_q;
	logic [CWD-1:0]          p_q;
	logic [IW-1:0]           i_q;
	logic [CWD-1:0]          xl_q;
	logic [CWD-1:0]          yl_q;
	logic [CWD-1:0]          xr_q;
	logic [CWD-1:0]          yr_q;
	logic [CWD-1:0]          px_q;
	logic [CWD-1:0]          py_q;
	logic [TW-1:0]           t_q;
	logic [RIW-1:0]          idx_q;
	logic [FRAC_BITS-1:0]    fr_q;
	logic [FRAC_BITS-1:0]    lo_q;
	logic                    mirror_q;
	logic [CWD-1:0]          w_q;
	logic signed [ACW-1:0]   acc_q;
	logic                    out_valid_q;
	logic [15:0]             out_value_q;
	logic [CWD-1:0]          out_weight_q;

	ceb_pkg::ceb_cfg_t       cfg;
	ceb_pkg::ceb_div_req_t   div_req;
	logic                    div_done;
	logic [TW-1:0]           div_quot;
	logic [CWD-1:0]          pt_x;
	logic [CWD-1:0]          pt_y;
	logic signed [AW-1:0]    mul_a;
	logic [BW-1:0]           mul_b;
	logic signed [PW-1:0]    prod;

	logic                    in_accept;
	logic [CWD-1:0]          in_p;
	logic [CWD-1:0]          in_p_sat;
	logic                    more_points;
	logic [CWD-1:0]          w_exact;
	logic                    div_ok;
	logic [TW-1:0]           t_div;
	logic                    t_mirror;
	logic [TW-1:0]           u_full;
	logic [PSW-1:0]          pos;
	logic [RIW-1:0]          idx_next;
	logic [FRAC_BITS-1:0]    fr_next;
	logic [FRAC_BITS-1:0]    rom_lo;
	logic [FRAC_BITS-1:0]    rom_hi;
	logic [FRAC_BITS-1:0]    rom_diff;
	logic [FRAC_BITS:0]      vsum;
	logic [FRAC_BITS-1:0]    v_clamp;
	logic [TW-1:0]           t_smooth;
	logic                    y_ge;
	logic [CWD-1:0]          dy;
	logic [CWD-1:0]          y_step;
	logic [CWD:0]            wsum;
	logic [CWD-1:0]          w_blend;
	logic signed [16:0]      dvs;
	logic signed [ACW-1:0]   acc_next;
	logic [15:0]             value_round;

	ceb_regs #(
		.MAX_POINTS(MAX_POINTS)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.rd_idx   (i_q),
		.cfg      (cfg),
		.rd_x     (pt_x),
		.rd_y     (pt_y)
	);

	ceb_div #(
		.QW(TW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	ceb_mul #(
		.AW(AW),
		.BW(BW)
	) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_comb begin
		in_accept = s_axis_tvalid && s_axis_tready;
		in_p = s_axis_tdata[48:32];
		in_p_sat = (in_p > ceb_pkg::ONE_Q16) ? ceb_pkg::ONE_Q16 : in_p;

		more_points = (4'(i_q) + 4'd1) < 4'(cfg.count);
		w_exact = (pt_y > ceb_pkg::ONE_Q16) ? ceb_pkg::ONE_Q16 : pt_y;

		div_ok = (xr_q > xl_q) && (p_q > xl_q);
		div_req.start = (state_q == ST_DIV_GO) && div_ok;
		div_req.num = p_q - xl_q;
		div_req.den = xr_q - xl_q;
		t_div = (div_quot > FULL) ? FULL : div_quot;

		t_mirror = t_q > TW'(HALF);
		u_full = t_mirror ? (FULL - t_q) : t_q;
		pos = {u_full[FRAC_BITS-1:0], RIW'(0)};
		if (pos[PSW-1]) begin
			idx_next = RIW'(ROM_N);
			fr_next = '0;
		end else begin
			idx_next = pos[PSW-1:FRAC_BITS];
			fr_next = pos[FRAC_BITS-1:0];
		end

		rom_lo = cos_rom[idx_q];
		rom_hi = cos_rom[idx_q + RIW'(1)];
		rom_diff = (rom_hi > rom_lo) ? (rom_hi - rom_lo) : '0;

		vsum = (FRAC_BITS + 1)'(lo_q) + (FRAC_BITS + 1)'(prod[FRAC_BITS +: FRAC_BITS]);
		v_clamp = (vsum > (FRAC_BITS + 1)'(HALF)) ? HALF : vsum[FRAC_BITS-1:0];
		t_smooth = mirror_q ? (FULL - TW'(v_clamp)) : TW'(v_clamp);

		y_ge = yr_q >= yl_q;
		dy = y_ge ? (yr_q - yl_q) : (yl_q - yr_q);
		y_step = prod[FRAC_BITS +: CWD];
		wsum = y_ge ? ((CWD + 1)'(yl_q) + (CWD + 1)'(y_step))
			: ((CWD + 1)'(yl_q) - (CWD + 1)'(y_step));
		w_blend = (wsum > (CWD + 1)'(ceb_pkg::ONE_Q16)) ? ceb_pkg::ONE_Q16 : wsum[CWD-1:0];

		dvs = 17'(ev_q) - 17'(sv_q);
		acc_next = (ACW'(sv_q) <<< 16) + prod[ACW-1:0];
		value_round = acc_q[31:16] + 16'(acc_q[ACW-1] && (acc_q[15:0] != 16'd0));

		case (state_q)
			ST_SM_MUL: begin
				mul_a = AW'(rom_diff);
				mul_b = BW'(fr_q);
			end
			ST_Y_MUL: begin
				mul_a = AW'(dy);
				mul_b = BW'(t_q);
			end
			ST_O_MUL: begin
				mul_a = AW'(dvs);
				mul_b = BW'(w_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sv_q <= '0;
			ev_q <= '0;
			p_q <= '0;
			i_q <= '0;
			xl_q <= '0;
			yl_q <= '0;
			xr_q <= '0;
			yr_q <= '0;
			px_q <= '0;
			py_q <= '0;
			t_q <= '0;
			idx_q <= '0;
			fr_q <= '0;
			lo_q <= '0;
			mirror_q <= 1'b0;
			w_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_weight_q <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						sv_q <= s_axis_tdata[15:0];
						ev_q <= s_axis_tdata[31:16];
						p_q <= in_p_sat;
						i_q <= '0;
						xl_q <= '0;
						yl_q <= '0;
						xr_q <= ceb_pkg::ONE_Q16;
						yr_q <= ceb_pkg::ONE_Q16;
						px_q <= '0;
						py_q <= '0;
						state_q <= (cfg.count == 3'd0) ? ST_DIV_GO : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (pt_x == p_q) begin
						w_q <= w_exact;
						state_q <= ST_O_MUL;
					end else if (pt_x < p_q) begin
						if (more_points) begin
							px_q <= pt_x;
							py_q <= pt_y;
							i_q <= i_q + IW'(1);
						end else begin
							xl_q <= pt_x;
							yl_q <= pt_y;
							state_q <= ST_DIV_GO;
						end
					end else begin
						xr_q <= pt_x;
						yr_q <= pt_y;
						xl_q <= px_q;
						yl_q <= py_q;
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: begin
					if (div_ok) begin
						state_q <= ST_DIV_WAIT;
					end else begin
						t_q <= '0;
						state_q <= cfg.mode ? ST_SM_IDX : ST_Y_MUL;
					end
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						t_q <= t_div;
						state_q <= cfg.mode ? ST_SM_IDX : ST_Y_MUL;
					end
				end
				ST_SM_IDX: begin
					mirror_q <= t_mirror;
					idx_q <= idx_next;
					fr_q <= fr_next;
					state_q <= ST_SM_MUL;
				end
				ST_SM_MUL: begin
					lo_q <= rom_lo;
					state_q <= ST_SM_FIN;
				end
				ST_SM_FIN: begin
					t_q <= t_smooth;
					state_q <= ST_Y_MUL;
				end
				ST_Y_MUL: begin
					state_q <= ST_Y_FIN;
				end
				ST_Y_FIN: begin
					w_q <= w_blend;
					state_q <= ST_O_MUL;
				end
				ST_O_MUL: begin
					state_q <= ST_O_FIN;
				end
				ST_O_FIN: begin
					acc_q <= acc_next;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_value_q <= value_round;
						out_weight_q <= w_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'd0, out_weight_q, out_value_q};

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_WAIT))
		else $error("Divider finished outside its wait state.");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_weight_q <= ceb_pkg::ONE_Q16))
		else $error("Curve weight above one.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_axis_tready)
		else $error("Input ready right after an accepted transfer.");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("Result loaded outside the output state.");

endmodule

`default_nettype wire
